FILE: hdl/lds_pkg.sv
// lds_pkg: shared types, constants and the alpha lookup table for the
// life-with-decay stencil block. No dependencies.
`default_nettype none

package lds_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CELL_W    = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int PIXEL_W   = 32;
    localparam int ALPHA_LSB = 24;
    localparam int LIVE_NUM  = 100;
    localparam int FULL_NUM  = 255;

    localparam logic [CELL_W-1:0] LIVE_VALUE = CELL_W'(LIVE_NUM);
    localparam logic [CELL_W-1:0] HALF_VALUE = CELL_W'(LIVE_NUM / 2);
    localparam logic [ALPHA_LSB-1:0] RGB_WHITE = '1;

    localparam int MIN_SIZE   = 3;
    localparam int FIRST_INNER = 2;
    localparam logic [CFG_W-1:0] RESET_SIZE = CFG_W'(64);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

    // one column of the 3x3 window
    typedef struct packed {
        logic [CELL_W-1:0] top;
        logic [CELL_W-1:0] mid;
        logic [CELL_W-1:0] bot;
    } t_column;

    // per-item control carried alongside the window data
    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } t_stage;

    typedef logic [CELL_W-1:0] t_lut [256];

    // alpha = next * 255 / 100, kept to 8 bits
    function automatic t_lut build_alpha_lut();
        t_lut lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = CELL_W'((i * FULL_NUM) / LIVE_NUM);
        end
        return lut;
    endfunction

    localparam t_lut ALPHA_LUT = build_alpha_lut();

endpackage

`default_nettype wire

FILE: hdl/lds_line_store.sv
// lds_line_store: single-port-write, registered-read memory holding the two
// previous rows of the grid, one 16-bit word per column. Uses lds_pkg.
`default_nettype none

module lds_line_store #(
    parameter int DEPTH  = lds_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rd_en,
    input  wire logic [ADDR_W-1:0]         i_rd_addr,
    output      logic [2*lds_pkg::CELL_W-1:0] o_rd_data,
    input  wire logic                      i_wr_en,
    input  wire logic [ADDR_W-1:0]         i_wr_addr,
    input  wire logic [2*lds_pkg::CELL_W-1:0] i_wr_data
);

    logic [2*lds_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [2*lds_pkg::CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hdl/lds_col_cell.sv
// lds_col_cell: one column of the 3x3 window; takes the column from its right
// neighbor on each shift. Uses lds_pkg.
`default_nettype none

module lds_col_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_shift,
    input  wire lds_pkg::t_column i_col,
    output      lds_pkg::t_column o_col
);

    lds_pkg::t_column r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

FILE: hdl/lds_rule.sv
// lds_rule: life-with-decay rule on the shifted window and the output
// register of the result stream. Uses lds_pkg.
`default_nettype none

module lds_rule (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire lds_pkg::t_stage  i_stage,
    input  wire lds_pkg::t_column i_left,
    input  wire lds_pkg::t_column i_centre,
    input  wire lds_pkg::t_column i_right,
    output      logic             o_valid,
    output      logic [lds_pkg::CELL_W-1:0]  o_next_value,
    output      logic [lds_pkg::PIXEL_W-1:0] o_pixel,
    output      logic             o_frame_end
);

    logic [3:0]                  live_count;
    logic                        self_live;
    logic [lds_pkg::CELL_W-1:0]  n_next;
    logic                        r_valid;
    logic [lds_pkg::CELL_W-1:0]  r_next;
    logic                        r_last;

    always_comb begin
        live_count = 4'(i_left.top   == lds_pkg::LIVE_VALUE)
                   + 4'(i_left.mid   == lds_pkg::LIVE_VALUE)
                   + 4'(i_left.bot   == lds_pkg::LIVE_VALUE)
                   + 4'(i_centre.top == lds_pkg::LIVE_VALUE)
                   + 4'(i_centre.bot == lds_pkg::LIVE_VALUE)
                   + 4'(i_right.top  == lds_pkg::LIVE_VALUE)
                   + 4'(i_right.mid  == lds_pkg::LIVE_VALUE)
                   + 4'(i_right.bot  == lds_pkg::LIVE_VALUE);
        self_live = (i_centre.mid == lds_pkg::LIVE_VALUE);
        if (live_count == 4'd3 || (live_count == 4'd2 && self_live)) begin
            n_next = lds_pkg::LIVE_VALUE;
        end else if (self_live) begin
            n_next = lds_pkg::HALF_VALUE;
        end else if (i_centre.mid != '0) begin
            n_next = i_centre.mid - 1'b1;
        end else begin
            n_next = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid && i_stage.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_stage.valid && i_stage.emit) begin
            r_next <= n_next;
            r_last <= i_stage.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_next_value = r_next;
    assign o_pixel      = {lds_pkg::ALPHA_LUT[r_next], lds_pkg::RGB_WHITE};
    assign o_frame_end  = r_last;

endmodule

`default_nettype wire

FILE: hdl/life_with_decay_stencil_core.sv
// life_with_decay_stencil_core: top level; raster counters, line store,
// window cell chain and rule stage. Uses lds_pkg, lds_line_store,
// lds_col_cell and lds_rule.
//
//  channel  direction  handshake                 payload
//  s        in         i_s_tvalid / o_s_tready   i_s_tdata: cell_value
//  m        out        o_m_tvalid / i_m_tready   o_m_tdata: next_value, pixel; o_m_tlast
//  cfg      in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one cell accepted per cycle while m is not stalled; the result of the cell
// that completes its 3x3 neighborhood passes the registered line store read
// and then the output register. the whole pipeline advances together whenever
// the output register is empty or being taken, so a stall on m holds s.
// reset (synchronous, active low) clears counters, valids and window and sets
// both sizes to 64. the line store is not cleared.
`default_nettype none

module life_with_decay_stencil_core #(
    parameter int MAX_WIDTH  = lds_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lds_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] cell_value
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [39:0] o_m_tdata,   // [7:0] next_value, [39:8] pixel
    output      logic        o_m_tlast,   // frame_end
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [lds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lds_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W = $clog2(MAX_HEIGHT + 1);
    localparam int SZ_W0 = (WSZ_W > HSZ_W) ? WSZ_W : HSZ_W;
    localparam int CMP_W = (SZ_W0 > lds_pkg::CFG_W) ? SZ_W0 : lds_pkg::CFG_W;
    localparam int CW    = lds_pkg::CELL_W;

    logic [lds_pkg::CFG_W-1:0] r_grid_width;
    logic [lds_pkg::CFG_W-1:0] r_grid_height;
    logic [COL_W-1:0]          r_col;
    logic [ROW_W-1:0]          r_row;
    logic [COL_W-1:0]          n_col;
    logic [ROW_W-1:0]          n_row;

    logic [CMP_W-1:0] cfg_w;
    logic [CMP_W-1:0] cfg_h;
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] h_eff;
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] row_ext;
    logic             col_wrap;
    logic             row_wrap;
    logic             emit;
    logic             last;

    logic             en;
    logic             s_accept;

    // stage a: item waiting for its line store read
    lds_pkg::t_stage  r_a;
    logic [COL_W-1:0] r_a_col;
    logic [CW-1:0]    r_a_value;
    logic [2*CW-1:0]  rd_data;
    logic             a_fire;

    lds_pkg::t_column new_col;
    lds_pkg::t_column cell_col [2];

    logic             m_valid;
    logic [CW-1:0]    m_next;
    logic [lds_pkg::PIXEL_W-1:0] m_pixel;
    logic             m_last;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= lds_pkg::RESET_SIZE;
            r_grid_height <= lds_pkg::RESET_SIZE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lds_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                lds_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped sizes and raster position
    always_comb begin
        cfg_w = CMP_W'(r_grid_width);
        cfg_h = CMP_W'(r_grid_height);
        if (cfg_w < CMP_W'(lds_pkg::MIN_SIZE)) begin
            w_eff = CMP_W'(lds_pkg::MIN_SIZE);
        end else if (cfg_w > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = cfg_w;
        end
        if (cfg_h < CMP_W'(lds_pkg::MIN_SIZE)) begin
            h_eff = CMP_W'(lds_pkg::MIN_SIZE);
        end else if (cfg_h > CMP_W'(MAX_HEIGHT)) begin
            h_eff = CMP_W'(MAX_HEIGHT);
        end else begin
            h_eff = cfg_h;
        end
        col_ext  = CMP_W'(r_col);
        row_ext  = CMP_W'(r_row);
        col_wrap = (col_ext + 1'b1) >= w_eff;
        row_wrap = (row_ext + 1'b1) >= h_eff;
        emit = (row_ext >= CMP_W'(lds_pkg::FIRST_INNER))
            && (col_ext >= CMP_W'(lds_pkg::FIRST_INNER))
            && (row_ext < h_eff) && (col_ext < w_eff);
        last = (row_ext == h_eff - 1'b1) && (col_ext == w_eff - 1'b1);

        n_col = r_col;
        n_row = r_row;
        if (s_accept) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // whole pipeline moves when the output register is free
    assign en         = !m_valid || i_m_tready;
    assign o_s_tready = en;
    assign s_accept   = i_s_tvalid && en;
    assign a_fire     = en && r_a.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
        end else if (en) begin
            r_a.valid <= i_s_tvalid;
            r_a.emit  <= emit;
            r_a.last  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_col   <= r_col;
            r_a_value <= i_s_tdata;
        end
    end

    // word layout: upper byte two rows up, lower byte one row up
    lds_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (s_accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (a_fire),
        .i_wr_addr (r_a_col),
        .i_wr_data ({rd_data[CW-1:0], r_a_value})
    );

    assign new_col.top = rd_data[2*CW-1:CW];
    assign new_col.mid = rd_data[CW-1:0];
    assign new_col.bot = r_a_value;

    // cell 1 takes the newest column, cell 0 takes from cell 1
    lds_col_cell u_cell_1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (a_fire),
        .i_col   (new_col),
        .o_col   (cell_col[1])
    );

    lds_col_cell u_cell_0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (a_fire),
        .i_col   (cell_col[1]),
        .o_col   (cell_col[0])
    );

    lds_rule u_rule (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_stage      (r_a),
        .i_left       (cell_col[0]),
        .i_centre     (cell_col[1]),
        .i_right      (new_col),
        .o_valid      (m_valid),
        .o_next_value (m_next),
        .o_pixel      (m_pixel),
        .o_frame_end  (m_last)
    );

    assign o_m_tvalid = m_valid;
    assign o_m_tdata  = {m_pixel, m_next};
    assign o_m_tlast  = m_last;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// testbench for life_with_decay_stencil_core: streams padded grids cell by cell and checks
// every next-generation value, pixel and frame-end flag against an in-bench predictor.
// depends on lds_pkg and the core RTL.

module testbench;

    localparam int MAX_W         = lds_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H         = lds_pkg::MAX_HEIGHT_DEF;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef struct packed {
        logic [7:0]  next_value;
        logic [31:0] pixel;
        logic        frame_end;
    } t_cell_result;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_s_tvalid  = 1'b0;
    logic                              o_s_tready;
    logic [7:0]                        i_s_tdata   = '0;
    logic                              o_m_tvalid;
    logic                              i_m_tready  = 1'b0;
    logic [39:0]                       o_m_tdata;
    logic                              o_m_tlast;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [lds_pkg::CFG_IDX_W-1:0]     i_cfg_index = lds_pkg::REG_GRID_WIDTH;
    logic [lds_pkg::CFG_W-1:0]         i_cfg_data  = '0;

    life_with_decay_stencil_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [lds_pkg::CFG_W-1:0] width_reg  = lds_pkg::RESET_SIZE;
    logic [lds_pkg::CFG_W-1:0] height_reg = lds_pkg::RESET_SIZE;
    logic [7:0]   row_above [MAX_W];
    logic [7:0]   two_above [MAX_W];
    logic [7:0]   win [3][3] = '{default: '0};
    int unsigned  cell_col = 0;
    int unsigned  cell_row = 0;
    t_cell_result pending_cells [$];
    int           error_count = 0;

    // stimulus control
    int burst_left    = 0;
    bit gaps_on       = 1'b0;
    int stall_mode    = 0;
    bit hold_request  = 1'b0;

    // rows of three cells: birth from the border, survival, crowding, fading values
    logic [7:0] rule_case_cells [30] = '{
        8'd100, 8'd100, 8'd100,
        8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,
        8'd100, 8'd100, 8'd0,
        8'd0,   8'd100, 8'd0,
        8'd100, 8'd0,   8'd100,
        8'd255, 8'd1,   8'd99,
        8'd101, 8'd255, 8'd0,
        8'd0,   8'd50,  8'd0,
        8'd0,   8'd0,   8'd0
    };

    function automatic int unsigned clamp_size(input logic [lds_pkg::CFG_W-1:0] raw,
                                               input int unsigned hi);
        if (raw < lds_pkg::MIN_SIZE) return lds_pkg::MIN_SIZE;
        if (raw > hi) return hi;
        return raw;
    endfunction

    function automatic logic [7:0] life_rule();
        int unsigned n;
        logic [7:0]  center_val;
        logic        is_live;
        n = 0;
        center_val = win[1][1];
        is_live = (center_val == lds_pkg::LIVE_VALUE);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (!(r == 1 && c == 1) && win[r][c] == lds_pkg::LIVE_VALUE) n++;
            end
        end
        if (n == 3 || (n == 2 && is_live)) return lds_pkg::LIVE_VALUE;
        if (is_live) return lds_pkg::HALF_VALUE;
        if (center_val != 0) return center_val - 8'd1;
        return 8'd0;
    endfunction

    task automatic model_cell(input logic [7:0] v);
        int unsigned  w;
        int unsigned  h;
        logic [7:0]   top;
        logic [7:0]   mid;
        logic [7:0]   nv;
        logic [31:0]  alpha;
        t_cell_result res;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, MAX_H);
        top = '0;
        mid = '0;
        if (cell_col < MAX_W) begin
            top = two_above[cell_col];
            mid = row_above[cell_col];
            two_above[cell_col] = mid;
            row_above[cell_col] = v;
        end
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = v;
        // the window now centers on the cell one row up and one column left
        if (cell_row >= 2 && cell_col >= 2 && cell_row < h && cell_col < w) begin
            nv = life_rule();
            alpha = (int'(nv) * lds_pkg::FULL_NUM / lds_pkg::LIVE_NUM) % 256;
            res.next_value = nv;
            res.pixel = {alpha[7:0], lds_pkg::RGB_WHITE};
            res.frame_end = (cell_row == h - 1 && cell_col == w - 1);
            pending_cells.push_back(res);
        end
        if (cell_col + 1 >= w) begin
            cell_col = 0;
            cell_row = (cell_row + 1 >= h) ? 0 : cell_row + 1;
        end else begin
            cell_col = cell_col + 1;
        end
    endtask

    function automatic logic [7:0] random_cell(input int live_pct);
        if ($urandom_range(0, 99) < live_pct) return lds_pkg::LIVE_VALUE;
        if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 2));
    endfunction

    task automatic send_cell(input logic [7:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) begin
                gap = $urandom_range(0, 5);
                if (gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        do @(posedge i_clk); while (!o_s_tready);
        model_cell(v);
        burst_left--;
    endtask

    task automatic run_frames(input int frames, input int live_pct);
        int done;
        done = 0;
        while (done < frames) begin
            send_cell(random_cell(live_pct));
            if (cell_col == 0 && cell_row == 0) done++;
        end
    endtask

    // stop sending and let the pipeline empty before touching the registers
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [lds_pkg::CFG_W-1:0] w,
                            input logic [lds_pkg::CFG_W-1:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= lds_pkg::REG_GRID_WIDTH;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        width_reg = w;
        i_cfg_index <= lds_pkg::REG_GRID_HEIGHT;
        i_cfg_data  <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        height_reg = h;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= 10)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_cell_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_cells.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result with no request pending, tdata 0x%0h tlast %b",
                             $time, o_m_tdata, o_m_tlast);
            end else begin
                want = pending_cells.pop_front();
                compare_field("next_value", 32'(want.next_value), 32'(o_m_tdata[7:0]));
                compare_field("pixel", want.pixel, o_m_tdata[39:8]);
                compare_field("frame_end", 32'(want.frame_end), 32'(o_m_tlast));
            end
        end
    end

    // output side: ready, or alternating ready/stall runs, plus an optional long hold-off
    initial begin : receiver
        bit run_ready;
        int run_left;
        run_ready = 1'b1;
        run_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (stall_mode == 0) begin
                i_m_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_ready = !run_ready;
                    run_left = run_ready ? $urandom_range(1, 10)
                                         : $urandom_range(1, 3 * stall_mode);
                end
                run_left--;
                i_m_tready <= run_ready;
            end
        end
    end

    // default 64x64 size, first three rows only
    task automatic test_reset_size();
        gaps_on = 1'b1;
        stall_mode = 1;
        repeat (3 * 64) send_cell(random_cell(40));
        wait_idle();
    endtask

    // shrink while the row count sits past the new height; it must wrap without results
    task automatic test_resize_mid_frame();
        set_grid(11'd5, 11'd2);
        gaps_on = 1'b0;
        stall_mode = 2;
        run_frames(3, 40);
        wait_idle();
    endtask

    task automatic test_rule_cases();
        set_grid(11'd3, 11'd10);
        gaps_on = 1'b0;
        stall_mode = 0;
        foreach (rule_case_cells[i]) send_cell(rule_case_cells[i]);
        wait_idle();
    endtask

    task automatic test_random_grids();
        logic [lds_pkg::CFG_W-1:0] w;
        logic [lds_pkg::CFG_W-1:0] h;
        repeat (6) begin
            // now and then a size below the minimum, which clamps to three
            w = lds_pkg::CFG_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(3, 12));
            h = lds_pkg::CFG_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(3, 10));
            set_grid(w, h);
            gaps_on = 1'($urandom_range(0, 1));
            stall_mode = $urandom_range(0, 3);
            run_frames($urandom_range(1, 2), $urandom_range(20, 60));
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        set_grid(11'd12, 11'd10);
        gaps_on = 1'b0;
        stall_mode = 1;
        hold_request = 1'b1;
        run_frames(1, 40);
        wait_idle();
    endtask

    // height at its maximum, then cut short mid-frame
    task automatic test_tall_grid();
        set_grid(11'd0, 11'd1024);
        gaps_on = 1'b1;
        stall_mode = 1;
        repeat (3 * 40) send_cell(random_cell(40));
        wait_idle();
        set_grid(11'd0, 11'd3);
        run_frames(2, 40);
        wait_idle();
    endtask

    // width register all ones, then narrowed while the column sits past the new width
    task automatic test_wide_grid();
        set_grid(11'h7FF, 11'd3);
        gaps_on = 1'b1;
        stall_mode = 1;
        repeat (40) send_cell(random_cell(40));
        wait_idle();
        set_grid(11'd3, 11'd3);
        run_frames(1, 40);
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_size();
        test_resize_mid_frame();
        test_rule_cases();
        test_random_grids();
        test_backpressure();
        test_tall_grid();
        test_wide_grid();
        wait_idle();
        if (error_count == 0 && pending_cells.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
